// ===== hw/rtl/lpbb_pkg.sv =====
// ----------------------------------------------------------------------------
// lpbb_pkg
// Shared constants, request codes and per-LED state type for the LED PWM
// breathing / blink driver.
// ----------------------------------------------------------------------------
package lpbb_pkg;

  // LEDs actually driven (1..4); the state array always has LED_SLOTS entries
  localparam int unsigned NUM_LEDS  = 4;
  localparam int unsigned LED_SLOTS = 4;
  localparam int unsigned LED_IDX_W = 2;

  localparam int unsigned PWM_STEPS      = 100;
  localparam int unsigned BLINK_DIV      = 100;
  localparam int unsigned GRAD_DIV       = 5;
  localparam int unsigned DWELL_DARK     = 10;
  localparam int unsigned DWELL_LIT      = 1;
  localparam int unsigned DWELL_MAX      = 15;
  localparam int unsigned REPEAT_FOREVER = 100;

  localparam int unsigned CFG_IDX_W = 2;

  // request codes
  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_OFF     = 3'd1;
  localparam logic [2:0] REQ_ON      = 3'd2;
  localparam logic [2:0] REQ_TOGGLE  = 3'd3;
  localparam logic [2:0] REQ_BREATHE = 3'd4;
  localparam logic [2:0] REQ_BLINK   = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON_SLOTS = 2'd1;

  typedef struct packed {
    logic       pin;
    logic [6:0] phase;
    logic [6:0] duty;
    logic       breathe;
    logic       falling;
    logic [3:0] dwell;
    logic [6:0] slot_tick;
    logic [7:0] slot_count;
    logic [6:0] burst_done;
    logic [6:0] lit;
    logic [6:0] mute;
    logic [6:0] repeats;
  } led_state_t;

endpackage

// ===== hw/rtl/led_pwm_breathe_blink_driver.sv =====
// ----------------------------------------------------------------------------
// led_pwm_breathe_blink_driver
// Per-LED 100-step PWM with breathing ramps and blink bursts; returns the
// pin bitmap after every request word.
// ----------------------------------------------------------------------------
// Timing: led_pins is registered and is valid in the cycle after input accept.
// Throughput: one word per cycle unless out_ready stalls; all LEDs update
// in parallel; the output register frees as taken, so both can move together.
// Reset (synchronous): all LED state and tick dividers cleared, blink_period
// = 3, blink_on_slots = 2, output empty.
module led_pwm_breathe_blink_driver
  import lpbb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           req_type,
  input  logic [LED_IDX_W-1:0] led_index,
  input  logic [6:0]           burst_on,
  input  logic [6:0]           burst_mute,
  input  logic [6:0]           repeat_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [LED_SLOTS-1:0] led_pins,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [6:0]           cfg_data
);

  logic [6:0] blink_period;
  logic [6:0] blink_on_slots;

  // only the residues of the ms counter modulo 100 and modulo 5 are kept
  logic [6:0] ms_mod100, ms_mod100_next;
  logic [2:0] ms_mod5, ms_mod5_next;

  led_state_t led_q    [LED_SLOTS];
  led_state_t led_next [LED_SLOTS];

  logic [LED_SLOTS-1:0] pins_next;
  logic                 in_fire;
  logic                 is_tick;
  logic                 blink_fire;
  logic                 grad_fire;
  logic                 cfg_period_wr;
  logic                 duty_ok;

  assign in_ready      = !out_valid || out_ready;
  assign cfg_ready     = 1'b1;
  assign in_fire       = in_valid && in_ready;
  assign is_tick       = (req_type == REQ_TICK);
  assign cfg_period_wr = cfg_valid && cfg_ready && (cfg_index == CFG_BLINK_PERIOD);

  always_comb begin
    ms_mod100_next = ms_mod100;
    ms_mod5_next   = ms_mod5;
    if (in_fire && is_tick) begin
      ms_mod100_next = (ms_mod100 == 7'(BLINK_DIV - 1)) ? 7'd0 : ms_mod100 + 7'd1;
      ms_mod5_next   = (ms_mod5 == 3'(GRAD_DIV - 1)) ? 3'd0 : ms_mod5 + 3'd1;
    end
    blink_fire = (ms_mod100_next == 7'd0);
    grad_fire  = (ms_mod5_next == 3'd0);
    // a period write restarts the millisecond count
    if (cfg_period_wr) begin
      ms_mod100_next = 7'd0;
      ms_mod5_next   = 3'd0;
    end
  end

  always_comb begin
    led_state_t s;
    logic [7:0] t;
    logic [8:0] c;
    logic [7:0] span;
    logic [7:0] r;
    logic [7:0] p;
    logic       lvl;
    for (int i = 0; i < LED_SLOTS; i++) begin
      s    = led_q[i];
      t    = {1'b0, s.slot_tick} + 8'd1;
      c    = {1'b0, s.slot_count} + 9'd1;
      span = {1'b0, s.lit} + {1'b0, s.mute};
      r    = {1'b0, s.burst_done} + 8'd1;
      p    = {1'b0, s.phase} + 8'd1;
      lvl  = 1'b0;
      if (in_fire && (i < NUM_LEDS)) begin
        if (is_tick) begin
          // blink runs before breathing; both may touch duty on one tick
          if ((s.lit != 7'd0) && blink_fire) begin
            if (t >= {1'b0, blink_period}) begin
              s.slot_tick = 7'd0;
              if (c >= {1'b0, span}) begin
                s.slot_count = 8'd0;
                if (r >= {1'b0, s.repeats}) begin
                  s.burst_done = 7'd0;
                  if (s.repeats < 7'(REPEAT_FOREVER))
                    s.lit = 7'd0;
                end else begin
                  s.burst_done = r[6:0];
                end
              end else begin
                s.slot_count = c[7:0];
              end
            end else begin
              s.slot_tick = t[6:0];
              if (t >= {1'b0, blink_on_slots})
                s.duty = 7'd0;
              else if (s.slot_count < {1'b0, s.lit})
                s.duty = 7'(PWM_STEPS);
            end
          end
          if (s.breathe && grad_fire) begin
            if (s.falling) begin
              if (s.duty != 7'd0) begin
                s.duty  = s.duty - 7'd1;
                s.dwell = 4'd0;
              end else begin
                if (s.dwell < 4'(DWELL_MAX))
                  s.dwell = s.dwell + 4'd1;
                if (s.dwell >= 4'(DWELL_DARK))
                  s.falling = 1'b0;
              end
            end else begin
              if (s.duty < 7'(PWM_STEPS)) begin
                s.duty  = s.duty + 7'd1;
                s.dwell = 4'd0;
              end else begin
                if (s.dwell < 4'(DWELL_MAX))
                  s.dwell = s.dwell + 4'd1;
                if (s.dwell >= 4'(DWELL_LIT))
                  s.falling = 1'b1;
              end
            end
          end
          if (p >= 8'(PWM_STEPS))
            p = 8'd0;
          s.phase = p[6:0];
          s.pin   = (p[6:0] < s.duty);
        end else if (led_index == LED_IDX_W'(i)) begin
          case (req_type)
            REQ_OFF, REQ_ON, REQ_TOGGLE: begin
              if (req_type == REQ_TOGGLE)
                lvl = !s.pin;
              else
                lvl = (req_type == REQ_ON);
              s.breathe = 1'b0;
              s.lit     = 7'd0;
              s.duty    = lvl ? 7'(PWM_STEPS) : 7'd0;
              s.pin     = lvl;
            end
            REQ_BREATHE: begin
              s.duty    = 7'd0;
              s.falling = 1'b0;
              s.dwell   = 4'd0;
              s.breathe = 1'b1;
            end
            REQ_BLINK: begin
              s.lit        = burst_on;
              s.mute       = burst_mute;
              s.repeats    = repeat_count;
              s.slot_count = 8'd0;
              s.burst_done = 7'd0;
            end
            default: ;
          endcase
        end
      end
      if (cfg_period_wr)
        s.slot_tick = 7'd0;
      led_next[i]  = s;
      pins_next[i] = s.pin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_period   <= 7'd3;
      blink_on_slots <= 7'd2;
      ms_mod100      <= 7'd0;
      ms_mod5        <= 3'd0;
      out_valid      <= 1'b0;
      led_pins       <= '0;
      for (int i = 0; i < LED_SLOTS; i++)
        led_q[i] <= '0;
    end else begin
      ms_mod100 <= ms_mod100_next;
      ms_mod5   <= ms_mod5_next;
      for (int i = 0; i < LED_SLOTS; i++)
        led_q[i] <= led_next[i];
      if (in_fire) begin
        out_valid <= 1'b1;
        led_pins  <= pins_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLINK_PERIOD:   blink_period   <= cfg_data;
          CFG_BLINK_ON_SLOTS: blink_on_slots <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    duty_ok = 1'b1;
    for (int i = 0; i < LED_SLOTS; i++)
      if (led_q[i].duty > 7'(PWM_STEPS))
        duty_ok = 1'b0;
  end

  a_div_range: assert property (@(posedge clk) disable iff (rst)
    (ms_mod100 < 7'(BLINK_DIV)) && (ms_mod5 < 3'(GRAD_DIV)))
    else $error("tick divider out of range");

  a_duty_range: assert property (@(posedge clk) disable iff (rst) duty_ok)
    else $error("duty level above full scale");

  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (out_valid && (led_pins == $past(pins_next))))
    else $error("accepted word did not reach the output register");

  a_div_step: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && req_type == REQ_TICK && !cfg_valid && ms_mod5 == 3'd4)
      |=> (ms_mod5 == 3'd0))
    else $error("ms divider did not wrap");

endmodule
